// ===== rtl/core/dtw_pkg.sv =====
// dtw distance engine shared constants: default geometry of the template store and cost path
`timescale 1ns / 1ps

package dtw_pkg;

	// default number of template entries held in the store
	localparam int DEF_MAX_TEMPLATE_LEN = 256;
	// default width of a signed sample
	localparam int DEF_SAMPLE_WIDTH = 16;
	// default width of an accumulated cost
	localparam int DEF_COST_WIDTH = 48;

	// operation codes of an input beat
	localparam logic OP_TEMPLATE = 1'b0;
	localparam logic OP_OBSERVE  = 1'b1;

endpackage

// ===== rtl/core/dtw_in_if.sv =====
// sample channel interface: valid/ready handshake with operation, sample and last
`timescale 1ns / 1ps

interface dtw_in_if #(
	parameter int SAMPLE_WIDTH = dtw_pkg::DEF_SAMPLE_WIDTH
);
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           last;

	modport source (output valid, operation, sample, last, input ready);
	modport sink (input valid, operation, sample, last, output ready);
endinterface

// ===== rtl/core/dtw_out_if.sv =====
// result channel interface: valid/ready handshake with distance, status and overflow
`timescale 1ns / 1ps

interface dtw_out_if #(
	parameter int COST_WIDTH = dtw_pkg::DEF_COST_WIDTH
);
	logic                  valid;
	logic                  ready;
	logic [COST_WIDTH-1:0] distance;
	logic                  status;
	logic                  overflow;

	modport source (output valid, distance, status, overflow, input ready);
	modport sink (input valid, distance, status, overflow, output ready);
endinterface

// ===== rtl/core/dtw_distance_engine.sv =====
// dynamic time warping distance engine: template store, column sweep and result buffer
`timescale 1ns / 1ps

// Usage
//   samples: one beat per template or observation sample. operation 0 stores a
//   template sample (last closes the template; a sample after a closed template
//   starts a new one). operation 1 feeds one observation sample; the beat with
//   last set closes the observation and returns one result beat.
//   result: distance of the final cell, status (1 = no closed template, then
//   distance 0) and overflow (cost saturated or template truncated).
// Sweep
//   a template beat is stored without a sweep. an observation beat sweeps the stored cost
//   column once, one template entry per cycle through the read port of the
//   column memory, then through a 4-stage cost pipeline; the sample channel is
//   not ready until the sweep ends. an observation with no closed template is
//   answered without a sweep. a result is registered when the sweep ends.
// Reset and stalls
//   arst_n clears the template count and all flags; the memories hold garbage
//   and are never used before being written. a stalled receiver is covered by
//   a result register plus one spare slot; the sample channel stops during a
//   sweep and while both are full.
module dtw_distance_engine #(
	parameter int MAX_TEMPLATE_LEN = dtw_pkg::DEF_MAX_TEMPLATE_LEN,
	parameter int SAMPLE_WIDTH     = dtw_pkg::DEF_SAMPLE_WIDTH,
	parameter int COST_WIDTH       = dtw_pkg::DEF_COST_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	dtw_in_if.sink    samples,
	dtw_out_if.source result
);
	import dtw_pkg::*;

	localparam int CntW = $clog2(MAX_TEMPLATE_LEN + 1);
	localparam int IdxW = $clog2(MAX_TEMPLATE_LEN);
	localparam int SqW  = 2 * SAMPLE_WIDTH;
	localparam int XW   = (SqW > COST_WIDTH) ? SqW : COST_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_ISSUE = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	// storage
	logic signed [SAMPLE_WIDTH-1:0] tmpl_mem [MAX_TEMPLATE_LEN];
	logic [COST_WIDTH-1:0]          col_mem  [MAX_TEMPLATE_LEN];

	// control state
	state_t                         state_q;
	logic [CntW-1:0]                count_q;
	logic                           ready_q;
	logic                           started_q;
	logic                           trunc_q;
	logic                           ovf_q;
	logic [IdxW-1:0]                rd_idx_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic                           first_q;
	logic                           last_q;
	logic [COST_WIDTH-1:0]          new_q;
	logic [COST_WIDTH-1:0]          diag_q;

	// pipeline
	logic                           v_s1, v_s2, v_s3, v_s4;
	logic [IdxW-1:0]                idx_s1, idx_s2, idx_s3, idx_s4;
	logic                           n0_s1, n0_s2, n0_s3, n0_s4;
	logic                           end_s1, end_s2, end_s3, end_s4;
	logic signed [SAMPLE_WIDTH-1:0] tmpl_s1;
	logic [COST_WIDTH-1:0]          left_s1, left_s2, left_s3;
	logic [SAMPLE_WIDTH-1:0]        mag_s2;
	logic [SqW-1:0]                 sq_s3;
	logic [COST_WIDTH-1:0]          lc_s4;
	logic                           lc_sat_s4;
	logic [COST_WIDTH-1:0]          pre_s4;

	// result buffer
	logic                           out_valid_q;
	logic [COST_WIDTH-1:0]          out_dist_q;
	logic                           out_status_q;
	logic                           out_ovf_q;
	logic                           pend_valid_q;
	logic [COST_WIDTH-1:0]          pend_dist_q;
	logic                           pend_status_q;
	logic                           pend_ovf_q;

	// combinational
	logic                           in_acc;
	logic                           tmpl_we;
	logic [CntW-1:0]                eff_cnt;
	logic                           eff_room;
	logic                           issue;
	logic                           issue_end;
	logic [SAMPLE_WIDTH:0]          diff;
	logic [SAMPLE_WIDTH:0]          diff_neg;
	logic [XW-1:0]                  sq_ext;
	logic                           sq_sat;
	logic [COST_WIDTH-1:0]          best;
	logic [COST_WIDTH:0]            sum;
	logic                           add_sat;
	logic [COST_WIDTH-1:0]          cost_new;
	logic                           hit;
	logic                           finish;
	logic                           res_valid;
	logic [COST_WIDTH-1:0]          res_dist;
	logic                           res_status;
	logic                           res_ovf;
	logic                           out_free;

	// input handshake
	assign samples.ready = (state_q == S_IDLE) && !pend_valid_q;
	assign in_acc        = samples.valid && samples.ready;
	assign tmpl_we       = in_acc && (samples.operation == OP_TEMPLATE) && eff_room;

	// a closed template restarts the count on the next template beat
	assign eff_cnt  = ready_q ? '0 : count_q;
	assign eff_room = eff_cnt < CntW'(MAX_TEMPLATE_LEN);

	// sweep issue
	assign issue     = (state_q == S_ISSUE);
	assign issue_end = (CntW'(rd_idx_q) == count_q - CntW'(1));

	// local difference magnitude; always fits the sample width
	assign diff     = {tmpl_s1[SAMPLE_WIDTH-1], tmpl_s1} - {x_q[SAMPLE_WIDTH-1], x_q};
	assign diff_neg = -diff;

	// squared cost clamp
	assign sq_ext = XW'(sq_s3);
	assign sq_sat = sq_ext > XW'({COST_WIDTH{1'b1}});

	// final stage: best neighbour against the cell just written, saturating add
	always_comb begin
		if (first_q) begin
			best = n0_s4 ? '0 : new_q;
		end else if (n0_s4) begin
			best = pre_s4;
		end else begin
			best = (pre_s4 < new_q) ? pre_s4 : new_q;
		end
	end

	assign sum      = {1'b0, lc_s4} + {1'b0, best};
	assign add_sat  = sum[COST_WIDTH];
	assign cost_new = add_sat ? '1 : sum[COST_WIDTH-1:0];
	assign hit      = lc_sat_s4 || add_sat;
	assign finish   = v_s4 && end_s4;

	// result source: early status answer or end of a closing sweep
	assign res_valid  = (in_acc && (samples.operation == OP_OBSERVE) && !ready_q)
		|| (finish && last_q);
	assign res_dist   = finish ? cost_new : '0;
	assign res_status = !finish;
	assign res_ovf    = finish && (ovf_q || hit);

	assign out_free = !out_valid_q || result.ready;

	assign result.valid    = out_valid_q;
	assign result.distance = out_dist_q;
	assign result.status   = out_status_q;
	assign result.overflow = out_ovf_q;

	// template store: written on template beats, read during the sweep
	always_ff @(posedge clk) begin
		if (tmpl_we) begin
			tmpl_mem[eff_cnt[IdxW-1:0]] <= samples.sample;
		end
		if (issue) begin
			tmpl_s1 <= tmpl_mem[rd_idx_q];
		end
	end

	// cost column: entry n is read well before it is rewritten, and later
	// reads only touch higher entries, so read and write never collide
	always_ff @(posedge clk) begin
		if (v_s4) begin
			col_mem[idx_s4] <= cost_new;
		end
		if (issue) begin
			left_s1 <= col_mem[rd_idx_q];
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		n0_s1  <= (rd_idx_q == '0);
		end_s1 <= issue_end;

		idx_s2  <= idx_s1;
		n0_s2   <= n0_s1;
		end_s2  <= end_s1;
		left_s2 <= left_s1;
		mag_s2  <= diff[SAMPLE_WIDTH] ? diff_neg[SAMPLE_WIDTH-1:0] : diff[SAMPLE_WIDTH-1:0];

		idx_s3  <= idx_s2;
		n0_s3   <= n0_s2;
		end_s3  <= end_s2;
		left_s3 <= left_s2;
		sq_s3   <= SqW'(mag_s2) * SqW'(mag_s2);

		idx_s4    <= idx_s3;
		n0_s4     <= n0_s3;
		end_s4    <= end_s3;
		lc_sat_s4 <= sq_sat;
		lc_s4     <= sq_sat ? '1 : sq_ext[COST_WIDTH-1:0];
		pre_s4    <= (n0_s3 || left_s3 < diag_q) ? left_s3 : diag_q;

		// old value of the previous entry feeds the diagonal
		if (v_s3) begin
			diag_q <= left_s3;
		end
		if (v_s4) begin
			new_q <= cost_new;
		end
		if (in_acc && samples.operation == OP_OBSERVE) begin
			x_q     <= samples.sample;
			first_q <= !started_q;
			last_q  <= samples.last;
		end
	end

	// control: template bookkeeping, sweep sequencer, flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ready_q   <= 1'b0;
			started_q <= 1'b0;
			trunc_q   <= 1'b0;
			ovf_q     <= 1'b0;
			rd_idx_q  <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;

			if (v_s4) begin
				ovf_q <= ovf_q || hit;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc && samples.operation == OP_TEMPLATE) begin
						started_q <= 1'b0;
						ready_q   <= samples.last;
						if (eff_room) begin
							count_q <= eff_cnt + CntW'(1);
							trunc_q <= trunc_q && !ready_q;
						end else begin
							count_q <= eff_cnt;
							trunc_q <= 1'b1;
						end
					end else if (in_acc && ready_q) begin
						if (!started_q) begin
							ovf_q <= trunc_q;
						end
						rd_idx_q <= '0;
						state_q  <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					rd_idx_q <= rd_idx_q + IdxW'(1);
					if (issue_end) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (finish) begin
						started_q <= !last_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register plus one spare slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= res_valid;
			end else begin
				out_valid_q  <= res_valid;
			end
		end else if (res_valid) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_dist_q    <= pend_dist_q;
				out_status_q  <= pend_status_q;
				out_ovf_q     <= pend_ovf_q;
				pend_dist_q   <= res_dist;
				pend_status_q <= res_status;
				pend_ovf_q    <= res_ovf;
			end else begin
				out_dist_q   <= res_dist;
				out_status_q <= res_status;
				out_ovf_q    <= res_ovf;
			end
		end else if (res_valid) begin
			pend_dist_q   <= res_dist;
			pend_status_q <= res_status;
			pend_ovf_q    <= res_ovf;
		end
	end

	// checks
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !samples.ready)
		else $error("sample beat taken during a sweep");

	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("spare result slot filled while result register empty");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !pend_valid_q)
		else $error("result produced with both result slots full");

	a_write_in_template: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (CntW'(idx_s4) < count_q))
		else $error("column write beyond template length");

	a_finish_ends_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (state_q == S_IDLE) && !v_s4)
		else $error("sweep did not end after its last entry");

endmodule

// ===== tb/sv/dtw_distance_checker.sv =====
// scoreboard for the dtw distance engine: predicts each result beat and compares it
`timescale 1ns / 1ps

module dtw_distance_checker (
	input  logic clk,
	input  logic arst_n,
	dtw_in_if    samples,
	dtw_out_if   result,
	output int   fail_count,
	output int   outstanding
);
	import dtw_pkg::*;

	localparam int MAX_LEN  = DEF_MAX_TEMPLATE_LEN;
	localparam int SAMPLE_W = DEF_SAMPLE_WIDTH;
	localparam int COST_W   = DEF_COST_WIDTH;
	localparam int IDX_W    = $clog2(MAX_LEN);
	localparam logic [63:0] COST_MAX = (64'd1 << COST_W) - 64'd1;

	typedef struct packed {
		logic [COST_W-1:0] distance;
		logic              status;
		logic              overflow;
	} dtw_result_t;

	// shadow copy of the engine state
	logic signed [SAMPLE_W-1:0] tmpl_mem [MAX_LEN];
	logic [63:0]                col_mem [MAX_LEN];
	logic [8:0]                 tmpl_count;
	logic                       tmpl_ready;
	logic                       obs_active;
	logic                       cost_sat;
	logic                       tmpl_trunc;

	dtw_result_t distance_q [$];

	// squared difference, clamped at the cost width
	function automatic logic [63:0] sq_diff(logic signed [SAMPLE_W-1:0] a,
			logic signed [SAMPLE_W-1:0] b);
		longint          d;
		longint unsigned m;
		longint unsigned sq;
		d  = longint'(a) - longint'(b);
		m  = (d < 0) ? longint'(-d) : longint'(d);
		sq = m * m;
		if (sq > COST_MAX) begin
			cost_sat = 1'b1;
			return COST_MAX;
		end
		return sq;
	endfunction

	// saturating sum of two costs
	function automatic logic [63:0] cost_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (s < a || s > COST_MAX) begin
			cost_sat = 1'b1;
			return COST_MAX;
		end
		return s;
	endfunction

	function automatic logic [63:0] min3(logic [63:0] a, logic [63:0] b, logic [63:0] c);
		logic [63:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	// advance the shadow state by one sample beat, queue any result it causes
	task automatic track_sample(logic op, logic signed [SAMPLE_W-1:0] x, logic lst);
		logic [63:0]      diag;
		logic [63:0]      left;
		logic [63:0]      best;
		logic [IDX_W-1:0] last_idx;
		dtw_result_t      r;
		if (op == OP_TEMPLATE) begin
			// a sample after a closed template opens a new one
			if (tmpl_ready) begin
				tmpl_count = '0;
				tmpl_ready = 1'b0;
				tmpl_trunc = 1'b0;
			end
			obs_active = 1'b0;
			if (tmpl_count < MAX_LEN) begin
				tmpl_mem[tmpl_count[IDX_W-1:0]] = x;
				tmpl_count = tmpl_count + 9'd1;
			end else begin
				tmpl_trunc = 1'b1;
			end
			if (lst)
				tmpl_ready = 1'b1;
		end else if (!tmpl_ready || tmpl_count == 0) begin
			// no closed template: answered at once, state untouched
			r.distance = '0;
			r.status   = 1'b1;
			r.overflow = 1'b0;
			distance_q.push_back(r);
		end else begin
			if (!obs_active) begin
				// first column: only the lower neighbour exists
				cost_sat   = tmpl_trunc;
				col_mem[0] = sq_diff(tmpl_mem[0], x);
				for (int n = 1; n < tmpl_count; n++)
					col_mem[n] = cost_add(sq_diff(tmpl_mem[n], x), col_mem[n-1]);
				obs_active = 1'b1;
			end else begin
				diag       = col_mem[0];
				col_mem[0] = cost_add(sq_diff(tmpl_mem[0], x), diag);
				for (int n = 1; n < tmpl_count; n++) begin
					left       = col_mem[n];
					best       = min3(left, diag, col_mem[n-1]);
					col_mem[n] = cost_add(sq_diff(tmpl_mem[n], x), best);
					diag       = left;
				end
			end
			if (lst) begin
				last_idx   = IDX_W'(tmpl_count - 9'd1);
				r.distance = col_mem[last_idx][COST_W-1:0];
				r.status   = 1'b0;
				r.overflow = cost_sat;
				distance_q.push_back(r);
				obs_active = 1'b0;
			end
		end
	endtask

	task automatic note_failure(string what, dtw_result_t want, dtw_result_t got);
		fail_count++;
		if (fail_count <= 10)
			$display({"%0t: %s: expected distance=%0d status=%0d overflow=%0d,",
				" got distance=%0d status=%0d overflow=%0d"},
				$realtime, what, want.distance, want.status, want.overflow,
				got.distance, got.status, got.overflow);
	endtask

	// watch both channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		dtw_result_t got;
		dtw_result_t want;
		if (!arst_n) begin
			tmpl_count  = '0;
			tmpl_ready  = 1'b0;
			obs_active  = 1'b0;
			cost_sat    = 1'b0;
			tmpl_trunc  = 1'b0;
			fail_count  = 0;
			distance_q.delete();
			outstanding = 0;
		end else begin
			if (samples.valid && samples.ready)
				track_sample(samples.operation, samples.sample, samples.last);
			if (result.valid && result.ready) begin
				got.distance = result.distance;
				got.status   = result.status;
				got.overflow = result.overflow;
				if (distance_q.size() == 0) begin
					want = '0;
					note_failure("result beat with nothing expected", want, got);
				end else begin
					want = distance_q.pop_front();
					if (got.distance !== want.distance || got.status !== want.status
							|| got.overflow !== want.overflow)
						note_failure("result mismatch", want, got);
				end
			end
			outstanding = distance_q.size();
		end
	end

endmodule

// ===== tb/sv/dtw_distance_engine_tb.sv =====
// testbench top for the dtw distance engine: clock, reset, sample stimulus and verdict
`timescale 1ns / 1ps

module dtw_distance_engine_tb;
	import dtw_pkg::*;

	localparam int MAX_LEN      = DEF_MAX_TEMPLATE_LEN;
	localparam int SAMPLE_W     = DEF_SAMPLE_WIDTH;
	localparam int COST_W       = DEF_COST_WIDTH;
	localparam int ITEM_BEATS   = 550;
	localparam int DRAIN_CYCLES = MAX_LEN + 40;
	localparam int LIMIT_CYCLES = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	int   beats_sent = 0;
	bit   no_idle = 1'b0;
	int   fail_count;
	int   outstanding;

	dtw_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
	dtw_out_if #(.COST_WIDTH(COST_W))    out_ch ();

	dtw_distance_engine #(
		.MAX_TEMPLATE_LEN(MAX_LEN),
		.SAMPLE_WIDTH(SAMPLE_W),
		.COST_WIDTH(COST_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.result(out_ch)
	);

	dtw_distance_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.samples(in_ch),
		.result(out_ch),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sample values biased toward the extremes and small differences
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic signed [SAMPLE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = {1'b0, {(SAMPLE_W-1){1'b1}}};
			1: v = {1'b1, {(SAMPLE_W-1){1'b0}}};
			2: v = SAMPLE_W'(int'($urandom_range(0, 15)) - 8);
			default: v = SAMPLE_W'($urandom());
		endcase
		return v;
	endfunction

	// one beat on the sample channel, called and returning at a falling edge
	task automatic send_beat(logic op, logic signed [SAMPLE_W-1:0] smp, logic lst);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.operation <= op;
		in_ch.sample    <= smp;
		in_ch.last      <= lst;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic send_template(int len);
		for (int i = 0; i < len; i++)
			send_beat(OP_TEMPLATE, pick_sample(), i == len - 1);
	endtask

	task automatic send_observation(int len);
		for (int i = 0; i < len; i++)
			send_beat(OP_OBSERVE, pick_sample(), i == len - 1);
	endtask

	// result side back-pressure
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 2) == 0) ? idle_gap() : 0;
			if (stall == 0) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		int r;
		in_ch.valid     = 1'b0;
		in_ch.operation = OP_TEMPLATE;
		in_ch.sample    = '0;
		in_ch.last      = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// observations before any template
		send_beat(OP_OBSERVE, 16'sd0, 1'b0);
		send_beat(OP_OBSERVE, 16'sd5, 1'b1);
		// extreme samples, widest squared difference
		send_beat(OP_TEMPLATE, 16'sh7fff, 1'b0);
		send_beat(OP_TEMPLATE, 16'sh8000, 1'b0);
		send_beat(OP_TEMPLATE, 16'sd0, 1'b1);
		send_beat(OP_OBSERVE, 16'sh8000, 1'b0);
		send_beat(OP_OBSERVE, 16'sh7fff, 1'b1);
		send_beat(OP_OBSERVE, 16'sd0, 1'b1);
		// single-entry template
		send_beat(OP_TEMPLATE, -16'sd1, 1'b1);
		send_beat(OP_OBSERVE, 16'sh7fff, 1'b1);
		// observation against a template still open
		send_beat(OP_TEMPLATE, 16'sd5, 1'b0);
		send_beat(OP_TEMPLATE, 16'sd7, 1'b0);
		send_beat(OP_OBSERVE, 16'sd3, 1'b0);
		send_beat(OP_TEMPLATE, 16'sd9, 1'b1);
		send_beat(OP_OBSERVE, 16'sd1, 1'b0);
		send_beat(OP_OBSERVE, 16'sd2, 1'b1);
		// template beat abandons an observation in progress
		send_beat(OP_OBSERVE, 16'sd4, 1'b0);
		send_beat(OP_TEMPLATE, 16'sd100, 1'b1);
		send_beat(OP_OBSERVE, 16'sd100, 1'b1);

		// template past the store size: full store, truncated, overflow on every result
		send_template(MAX_LEN + 4);
		send_observation(2);
		send_observation(1);

		// random sequences until the item count is reached
		while (beats_sent < ITEM_BEATS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				// well-formed template then a few observations
				r = $urandom_range(0, 99);
				if (r < 60)
					send_template($urandom_range(1, 6));
				else if (r < 95)
					send_template($urandom_range(7, 24));
				else
					send_template($urandom_range(25, 80));
				repeat ($urandom_range(1, 4))
					send_observation($urandom_range(1, 8));
			end else if (r < 80) begin
				// observation cut short by a template beat
				repeat ($urandom_range(1, 3))
					send_beat(OP_OBSERVE, pick_sample(), 1'b0);
				send_beat(OP_TEMPLATE, pick_sample(), 1'($urandom_range(0, 1)));
				send_observation($urandom_range(1, 4));
			end else if (r < 90) begin
				// noise
				repeat ($urandom_range(1, 6))
					send_beat(1'($urandom_range(0, 1)), pick_sample(),
						1'($urandom_range(0, 1)));
			end else begin
				// open template, observation, then close it
				send_beat(OP_TEMPLATE, pick_sample(), 1'b0);
				send_beat(OP_TEMPLATE, pick_sample(), 1'b0);
				send_observation($urandom_range(1, 2));
				send_beat(OP_TEMPLATE, pick_sample(), 1'b1);
				send_observation($urandom_range(1, 5));
			end
		end
		in_ch.valid <= 1'b0;
		no_idle = 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
